[sv/tsdc_pkg.sv]
// Shared widths, codes and reset values of the track speed and distance controller.
package tsdc_pkg;

	localparam int SPEED_W = 11;
	localparam int DIST_W  = 24;
	localparam int DUTY_W  = 8;
	localparam int ACC_W   = 24;
	localparam int GAIN_W  = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [1:0] {
		CMD_TICK       = 2'd0,
		CMD_SPEED      = 2'd1,
		CMD_SPEED_DIST = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_SPEED  = 3'd0,
		CFG_MAX_SPEED  = 3'd1,
		CFG_PWM_MAX    = 3'd2,
		CFG_DIST_TOL   = 3'd3,
		CFG_SPEED_TOL  = 3'd4,
		CFG_STEP_GAIN  = 3'd5
	} cfg_idx_t;

	localparam logic [9:0]  RST_MIN_SPEED = 10'd10;
	localparam logic [9:0]  RST_MAX_SPEED = 10'd400;
	localparam logic [7:0]  RST_PWM_MAX   = 8'd255;
	localparam logic [15:0] RST_DIST_TOL  = 16'd20;
	localparam logic [9:0]  RST_SPEED_TOL = 10'd10;
	localparam logic [23:0] RST_STEP_GAIN = 24'd21391;

endpackage

[sv/tsdc_if.sv]
// Channel interfaces: command input, result output and configuration write.
interface tsdc_in_if;
	import tsdc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                cmd;
	logic signed [SPEED_W-1:0] target_speed;
	logic signed [DIST_W-1:0]  target_distance;
	logic signed [SPEED_W-1:0] measured_speed;
	logic signed [DIST_W-1:0]  measured_distance;

	modport source (output valid, cmd, target_speed, target_distance, measured_speed,
		measured_distance, input ready);
	modport sink (input valid, cmd, target_speed, target_distance, measured_speed,
		measured_distance, output ready);
endinterface

interface tsdc_out_if;
	import tsdc_pkg::*;
	logic              valid;
	logic              ready;
	logic              drive_up;
	logic              drive_down;
	logic [DUTY_W-1:0] duty;
	logic              duty_written;
	logic              reset_distance;
	logic              moving;

	modport source (output valid, drive_up, drive_down, duty, duty_written, reset_distance,
		moving, input ready);
	modport sink (input valid, drive_up, drive_down, duty, duty_written, reset_distance,
		moving, output ready);
endinterface

interface tsdc_cfg_if;
	import tsdc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/track_speed_distance_controller.sv]
// Top level: integral speed controller with distance stop and direction pins.
//
// channel | role   | transaction
// item    | sink   | one command or control tick
// result  | source | pins, duty and flags after that item
// cfg     | sink   | one register write, always ready
//
// One item per cycle sustained while result.ready holds; its result is valid the cycle after acceptance.
// The whole update (compare, 24x13 multiply, accumulate, clamp) is combinational
// logic between the channel and the state/result registers.
// A result held by result.ready stalls item.ready only when not taken that cycle.
// arst_n clears state, the result register and the registers to reset values.
module track_speed_distance_controller (
	input  logic               clk,
	input  logic               arst_n,
	tsdc_in_if.sink            item,
	tsdc_out_if.source         result,
	tsdc_cfg_if.sink           cfg
);
	import tsdc_pkg::*;

	logic [9:0]  min_speed_q;
	logic [9:0]  max_speed_q;
	logic [7:0]  pwm_max_q;
	logic [15:0] dist_tol_q;
	logic [9:0]  speed_tol_q;
	logic [23:0] step_gain_q;

	logic                      mode_q;
	logic signed [SPEED_W-1:0] st_q;
	logic [DIST_W-2:0]         dt_q;
	logic [ACC_W-1:0]          acc_q;
	logic                      motion_q;
	logic                      up_q;
	logic                      down_q;

	logic res_valid_q;
	logic res_written_q;
	logic res_rst_q;

	logic accept;

	logic [11:0]        ts_mag, st_mag;
	logic               ts_ok;
	logic signed [25:0] dist_diff;
	logic [25:0]        dist_mag;
	logic               stop;
	logic signed [12:0] delta;
	logic [12:0]        delta_mag;
	logic               adjust;
	logic signed [37:0] prod;
	logic signed [30:0] acc_sum, acc_fix, acc_top, acc_lim;

	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign result.valid          = res_valid_q;
	assign result.drive_up       = up_q;
	assign result.drive_down     = down_q;
	assign result.duty           = acc_q[ACC_W-1 -: DUTY_W];
	assign result.duty_written   = res_written_q;
	assign result.reset_distance = res_rst_q;
	assign result.moving         = motion_q;

	always_comb begin
		ts_mag = item.target_speed[SPEED_W-1] ? 12'(-{item.target_speed[SPEED_W-1],
			item.target_speed}) : {1'b0, item.target_speed};
		st_mag = st_q[SPEED_W-1] ? 12'(-{st_q[SPEED_W-1], st_q}) : {1'b0, st_q};
		ts_ok  = ts_mag <= {2'b00, max_speed_q};

		dist_diff = $signed({3'b000, dt_q})
			- $signed({{2{item.measured_distance[DIST_W-1]}}, item.measured_distance});
		dist_mag  = dist_diff[25] ? 26'(-dist_diff) : dist_diff;
		stop      = (!mode_q && (dist_mag <= {10'd0, dist_tol_q}))
			|| (st_mag < {2'b00, min_speed_q});

		delta     = $signed({1'b0, st_mag})
			- $signed({{2{item.measured_speed[SPEED_W-1]}}, item.measured_speed});
		delta_mag = delta[12] ? 13'(-delta) : delta;
		adjust    = delta_mag > {3'b000, speed_tol_q};

		prod    = $signed({1'b0, step_gain_q}) * delta;
		acc_sum = $signed({7'd0, acc_q}) + 31'($signed(prod[37:8]));
		acc_fix = acc_sum[30] ? $signed({5'd0, min_speed_q, 16'd0}) : acc_sum;
		acc_top = $signed({7'd0, pwm_max_q, 16'd0});
		acc_lim = (acc_fix > acc_top) ? acc_top : acc_fix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= RST_MIN_SPEED;
			max_speed_q <= RST_MAX_SPEED;
			pwm_max_q   <= RST_PWM_MAX;
			dist_tol_q  <= RST_DIST_TOL;
			speed_tol_q <= RST_SPEED_TOL;
			step_gain_q <= RST_STEP_GAIN;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MIN_SPEED: min_speed_q <= cfg.data[9:0];
				CFG_MAX_SPEED: max_speed_q <= cfg.data[9:0];
				CFG_PWM_MAX:   pwm_max_q   <= cfg.data[7:0];
				CFG_DIST_TOL:  dist_tol_q  <= cfg.data[15:0];
				CFG_SPEED_TOL: speed_tol_q <= cfg.data[9:0];
				CFG_STEP_GAIN: step_gain_q <= cfg.data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q   <= 1'b0;
			res_written_q <= 1'b0;
			res_rst_q     <= 1'b0;
			mode_q        <= 1'b0;
			st_q          <= '0;
			dt_q          <= '0;
			acc_q         <= '0;
			motion_q      <= 1'b0;
			up_q          <= 1'b0;
			down_q        <= 1'b0;
		end else begin
			if (result.ready)
				res_valid_q <= 1'b0;
			if (accept) begin
				res_valid_q   <= 1'b1;
				res_written_q <= 1'b0;
				res_rst_q     <= 1'b0;
				case (item.cmd)
					CMD_SPEED: begin
						mode_q    <= 1'b1;
						res_rst_q <= 1'b1;
						if (ts_ok)
							st_q <= item.target_speed;
					end
					CMD_SPEED_DIST: begin
						mode_q    <= 1'b0;
						res_rst_q <= 1'b1;
						if (ts_ok)
							st_q <= item.target_speed;
						if (!item.target_distance[DIST_W-1])
							dt_q <= item.target_distance[DIST_W-2:0];
					end
					CMD_TICK: begin
						if (stop) begin
							up_q      <= 1'b0;
							down_q    <= 1'b0;
							dt_q      <= '0;
							motion_q  <= 1'b0;
							res_rst_q <= 1'b1;
						end else if (adjust) begin
							motion_q      <= 1'b1;
							acc_q         <= acc_lim[ACC_W-1:0];
							up_q          <= !st_q[SPEED_W-1] && (st_q != '0);
							down_q        <= st_q[SPEED_W-1] || (st_q == '0);
							res_written_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

[sv/tsdc_checker.sv]
// Port-level checks on the controller's results, bound to the top level.
module tsdc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic              drive_up,
	input logic              drive_down,
	input logic [7:0]        duty,
	input logic              duty_written,
	input logic              reset_distance,
	input logic              moving
);
	import tsdc_pkg::*;

	logic [DUTY_W+4:0] payload;
	assign payload = {drive_up, drive_down, duty, duty_written, reset_distance, moving};

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(payload))
		else $error("result changed while stalled");

	// an update and a distance clear never come from the same transaction
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(duty_written && reset_distance))
		else $error("duty written together with distance reset");

	// a duty update drives exactly one direction pin
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && duty_written |-> moving && (drive_up != drive_down))
		else $error("duty update without single direction");

	// the pins are live exactly while the motor is marked moving
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (moving == (drive_up || drive_down)) && !(drive_up && drive_down))
		else $error("pins disagree with moving flag");

endmodule

bind track_speed_distance_controller tsdc_checker u_tsdc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.drive_up       (result.drive_up),
	.drive_down     (result.drive_down),
	.duty           (result.duty),
	.duty_written   (result.duty_written),
	.reset_distance (result.reset_distance),
	.moving         (result.moving)
);
